@@ hdl/fbct_pkg.sv @@
package fbct_pkg;

   localparam int CAPACITY      = 16;
   localparam int BLOCK_ID_BITS = 16;

   localparam int ID_BITS    = 16;
   localparam int SIZE_BITS  = 5;
   localparam int TAG_BITS   = (BLOCK_ID_BITS < ID_BITS) ? BLOCK_ID_BITS : ID_BITS;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_MARK   = 2'd2,
      ACT_FLUSH  = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic mark;
      logic clear;
      logic occupied;
   } cell_ctrl_type;

endpackage

@@ hdl/fbct_ifs.sv @@
interface fbct_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [fbct_pkg::ID_BITS-1:0] disk_block;

   modport source (output valid, action, disk_block, input ready);
   modport sink (input valid, action, disk_block, output ready);
endinterface

interface fbct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         writeback_valid;
   logic [fbct_pkg::ID_BITS-1:0] writeback_block;
   logic                         last_result;

   modport source (output valid, hit, writeback_valid, writeback_block, last_result,
                   input ready);
   modport sink (input valid, hit, writeback_valid, writeback_block, last_result,
                 output ready);
endinterface

interface fbct_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fbct_pkg::SIZE_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hdl/fbct_cell.sv @@
module fbct_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  fbct_pkg::cell_ctrl_type       ctrl,
   input  logic [fbct_pkg::TAG_BITS-1:0] id,
   input  logic [fbct_pkg::TAG_BITS-1:0] next_tag,
   input  logic                          next_dirty,
   output logic [fbct_pkg::TAG_BITS-1:0] tag,
   output logic                          dirty,
   output logic                          match
);

   logic [fbct_pkg::TAG_BITS-1:0] tag_ff;
   logic [fbct_pkg::TAG_BITS-1:0] tag_in;
   logic                          dirty_ff;
   logic                          dirty_in;

   assign match = ctrl.occupied && (tag_ff == id);
   assign tag   = tag_ff;
   assign dirty = dirty_ff;

   always_comb begin
      if (ctrl.load) begin
         tag_in = id;
      end else if (ctrl.shift) begin
         tag_in = next_tag;
      end else begin
         tag_in = tag_ff;
      end
   end

   always_comb begin
      if (ctrl.clear || ctrl.load) begin
         dirty_in = 1'b0;
      end else if (ctrl.shift) begin
         dirty_in = next_dirty;
      end else if (ctrl.mark && match) begin
         dirty_in = 1'b1;
      end else begin
         dirty_in = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
      end
   end

endmodule

@@ hdl/fifo_block_cache_tags.sv @@
// Directory of a FIFO-replaced, write-back block cache kept as a row of tag cells with the
// oldest entry in cell 0. Lookup, insert and mark-dirty each take one transaction per cycle:
// every cell compares its tag in parallel, and an insert into a full cache shifts the whole
// row down by one cell, evicting cell 0. A flush, once accepted, shifts the row one cell per
// cycle and emits each dirty id as it reaches cell 0, so it holds off requests until the
// last dirty entry has been emitted (not at all when nothing is dirty); a shift waits while
// the previous result is held up. Results leave through an output register, so a new
// request is taken while the previous result waits only if that result is taken in the
// same cycle. The size register is always ready; a write of zero is ignored.
module fifo_block_cache_tags (
   input  logic              clock,
   input  logic              reset,
   fbct_req_if.sink          req_bus,
   fbct_rsp_if.source        rsp_bus,
   fbct_csr_if.sink          csr_bus
);

   localparam int N = fbct_pkg::CAPACITY;

   fbct_pkg::state_type                 state_ff;
   fbct_pkg::state_type                 state_in;
   logic [fbct_pkg::SIZE_BITS-1:0]      size_ff;
   logic [fbct_pkg::SIZE_BITS-1:0]      size_in;
   logic [fbct_pkg::COUNT_BITS-1:0]     count_ff;
   logic [fbct_pkg::COUNT_BITS-1:0]     count_in;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic                                rsp_hit_ff;
   logic                                rsp_hit_in;
   logic                                rsp_wb_valid_ff;
   logic                                rsp_wb_valid_in;
   logic [fbct_pkg::ID_BITS-1:0]        rsp_wb_block_ff;
   logic [fbct_pkg::ID_BITS-1:0]        rsp_wb_block_in;
   logic                                rsp_last_ff;
   logic                                rsp_last_in;

   logic [fbct_pkg::TAG_BITS-1:0]       cell_tag [N];
   logic [fbct_pkg::TAG_BITS-1:0]       chain_tag [N];
   logic [N-1:0]                        cell_dirty;
   logic [N-1:0]                        chain_dirty;
   logic [N-1:0]                        cell_match;
   logic [N-1:0]                        occupied;
   logic [N-1:0]                        dirty_held;
   fbct_pkg::cell_ctrl_type             cell_ctrl [N];

   logic [fbct_pkg::TAG_BITS-1:0]       id;
   logic [fbct_pkg::CMP_BITS-1:0]       size_ext;
   logic [fbct_pkg::CMP_BITS-1:0]       size_eff;
   logic [fbct_pkg::COUNT_BITS-1:0]     insert_pos;
   logic                                full;
   logic                                any_dirty;
   logic                                rest_dirty;
   logic                                out_free;
   logic                                req_ready;
   logic                                accept;
   logic                                do_lookup;
   logic                                do_insert;
   logic                                do_mark;
   logic                                do_flush;
   logic                                flush_step;
   logic                                flush_emit;
   logic                                flush_done;

   assign id         = req_bus.disk_block[fbct_pkg::TAG_BITS-1:0];
   assign dirty_held = cell_dirty & occupied;
   assign any_dirty  = |dirty_held;
   assign rest_dirty = |(dirty_held >> 1);

   assign size_ext = fbct_pkg::CMP_BITS'(size_ff);
   assign size_eff = (size_ext > fbct_pkg::CMP_BITS'(N)) ? fbct_pkg::CMP_BITS'(N) : size_ext;
   assign full     = fbct_pkg::CMP_BITS'(count_ff) >= size_eff;
   assign insert_pos = full ? (count_ff - 1'b1) : count_ff;

   assign accept    = req_bus.valid && req_ready;
   assign do_lookup = accept && (req_bus.action == fbct_pkg::ACT_LOOKUP);
   assign do_insert = accept && (req_bus.action == fbct_pkg::ACT_INSERT);
   assign do_mark   = accept && (req_bus.action == fbct_pkg::ACT_MARK);
   assign do_flush  = accept && (req_bus.action == fbct_pkg::ACT_FLUSH);

   // handshake and flush sequencing
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_bus.ready;
      req_ready  = 1'b0;
      flush_step = 1'b0;
      case (state_ff)
         fbct_pkg::ST_IDLE: begin
            req_ready = out_free;
         end
         fbct_pkg::ST_FLUSH: begin
            flush_step = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      flush_emit = flush_step && dirty_held[0];
      flush_done = (do_flush && !any_dirty) || (flush_emit && !rest_dirty);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbct_pkg::ST_IDLE: begin
            if (do_flush && any_dirty) begin
               state_in = fbct_pkg::ST_FLUSH;
            end
         end
         fbct_pkg::ST_FLUSH: begin
            if (flush_emit && !rest_dirty) begin
               state_in = fbct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbct_pkg::ST_IDLE;
         end
      endcase
   end

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         if (i == N - 1) begin : g_end
            assign chain_tag[i]   = '0;
            assign chain_dirty[i] = 1'b0;
         end else begin : g_link
            assign chain_tag[i]   = cell_tag[i+1];
            assign chain_dirty[i] = cell_dirty[i+1];
         end

         assign occupied[i]           = count_ff > fbct_pkg::COUNT_BITS'(i);
         assign cell_ctrl[i].load     = do_insert && (insert_pos == fbct_pkg::COUNT_BITS'(i));
         assign cell_ctrl[i].shift    = (do_insert && full) || flush_step;
         assign cell_ctrl[i].mark     = do_mark;
         assign cell_ctrl[i].clear    = flush_done;
         assign cell_ctrl[i].occupied = occupied[i];

         fbct_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .id         (id),
            .next_tag   (chain_tag[i]),
            .next_dirty (chain_dirty[i]),
            .tag        (cell_tag[i]),
            .dirty      (cell_dirty[i]),
            .match      (cell_match[i])
         );
      end
   endgenerate

   always_comb begin
      if (flush_done) begin
         count_in = '0;
      end else if (flush_step) begin
         count_in = count_ff - 1'b1;
      end else if (do_insert && !full) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      size_in = size_ff;
      if (csr_bus.valid && (csr_bus.data != '0)) begin
         size_in = csr_bus.data;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_wb_valid_in = rsp_wb_valid_ff;
      rsp_wb_block_in = rsp_wb_block_ff;
      rsp_last_in     = rsp_last_ff;
      if (do_lookup || do_mark) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = |cell_match;
         rsp_wb_valid_in = 1'b0;
         rsp_wb_block_in = '0;
         rsp_last_in     = 1'b1;
      end else if (do_insert) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = 1'b0;
         rsp_wb_valid_in = full && dirty_held[0];
         rsp_wb_block_in = (full && dirty_held[0]) ? fbct_pkg::ID_BITS'(cell_tag[0]) : '0;
         rsp_last_in     = 1'b1;
      end else if (do_flush && !any_dirty) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = 1'b0;
         rsp_wb_valid_in = 1'b0;
         rsp_wb_block_in = '0;
         rsp_last_in     = 1'b1;
      end else if (flush_emit) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = 1'b0;
         rsp_wb_valid_in = 1'b1;
         rsp_wb_block_in = fbct_pkg::ID_BITS'(cell_tag[0]);
         rsp_last_in     = !rest_dirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbct_pkg::ST_IDLE;
         size_ff      <= fbct_pkg::SIZE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff      <= rsp_hit_in;
      rsp_wb_valid_ff <= rsp_wb_valid_in;
      rsp_wb_block_ff <= rsp_wb_block_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_bus.ready           = req_ready;
   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hit             = rsp_hit_ff;
   assign rsp_bus.writeback_valid = rsp_wb_valid_ff;
   assign rsp_bus.writeback_block = rsp_wb_block_ff;
   assign rsp_bus.last_result     = rsp_last_ff;

endmodule

@@ hdl/fbct_checker.sv @@
module fbct_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_hit,
   input logic rsp_wb_valid,
   input logic rsp_last
);

   // no transaction left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // only a writeback can be followed by more results of the same request
   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wb_valid |-> rsp_last)
      else $error("non-writeback result not marked last");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_wb_valid)
      else $error("hit and writeback in one result");

   // a flush in progress blocks new requests
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken while flush results pending");

endmodule

bind fifo_block_cache_tags fbct_checker u_fbct_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_hit      (rsp_bus.hit),
   .rsp_wb_valid (rsp_bus.writeback_valid),
   .rsp_last     (rsp_bus.last_result)
);
